FILE: rtl/core/rational_arithmetic_unit_macros.svh
// Assertion macros used by the checker file rau_checker.sv.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
// Concurrent implication, reset disabled.
`define RAU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, reset disabled.
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Widths and codes for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;
    localparam int OPERAND_WIDTH = 16;
    localparam int NUM_W = 33;
    localparam int DEN_W = 31;
    localparam int CMD_W = 2;
    localparam int ST_W  = 2;
    localparam int ACC_W = 64;

    localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 2'd3;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [ST_W-1:0] ST_DIV_ZERO = 2'd2;

    typedef struct packed {
        logic start;
        logic done;
    } t_ctl;
endpackage

FILE: rtl/core/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd
// Binary GCD followed by shift-subtract division of both values by the GCD.
// ----------------------------------------------------------------------------
module rau_gcd (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rau_pkg::t_ctl                 i_ctl,
    input  logic [rau_pkg::ACC_W-1:0]     i_mag,
    input  logic [rau_pkg::ACC_W-1:0]     i_den,
    output rau_pkg::t_ctl                 o_ctl,
    output logic [rau_pkg::ACC_W-1:0]     o_mag,
    output logic [rau_pkg::ACC_W-1:0]     o_den
);
    localparam int W = rau_pkg::ACC_W;
    localparam int CW = $clog2(W + 1);
    localparam logic [2:0] S_IDLE = 3'd0, S_GCD = 3'd1, S_DIVA = 3'd2,
                           S_DIVB = 3'd3, S_DONE = 3'd4;

    logic [2:0]    r_st, n_st;
    logic [W-1:0]  r_x, n_x, r_y, n_y, r_g, n_g;
    logic [CW-1:0] r_k, n_k, r_i, n_i;
    logic [W-1:0]  r_a, n_a, r_b, n_b;
    logic [W-1:0]  r_q, n_q;
    logic [W:0]    r_rem, n_rem;
    logic [W:0]    w_try;

    assign w_try = {r_rem[W-1:0], r_q[W-1]} - {1'b0, r_g};

    always_comb begin
        n_st = r_st; n_x = r_x; n_y = r_y; n_g = r_g; n_k = r_k; n_i = r_i;
        n_a = r_a; n_b = r_b; n_q = r_q; n_rem = r_rem;
        case (r_st)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_x = i_mag; n_y = i_den; n_a = i_mag; n_b = i_den;
                    n_k = '0; n_st = S_GCD;
                end
            end
            S_GCD: begin
                // one binary GCD step a cycle
                if (r_y == '0) begin
                    n_g = r_x << r_k; n_q = r_a; n_rem = '0;
                    n_i = CW'(W); n_st = S_DIVA;
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1; n_y = r_y >> 1; n_k = r_k + 1'b1;
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (r_x >= r_y) begin
                    n_x = r_y; n_y = (r_x - r_y) >> 1;
                end else begin
                    n_y = (r_y - r_x) >> 1;
                end
            end
            S_DIVA, S_DIVB: begin
                // restoring division, one quotient bit a cycle
                if (!w_try[W]) begin
                    n_rem = {1'b0, w_try[W-1:0]};
                    n_q = {r_q[W-2:0], 1'b1};
                end else begin
                    n_rem = {r_rem[W-1:0], r_q[W-1]};
                    n_q = {r_q[W-2:0], 1'b0};
                end
                n_i = r_i - 1'b1;
                if (r_i == CW'(1)) begin
                    if (r_st == S_DIVA) begin
                        n_a = n_q; n_q = r_b; n_rem = '0; n_i = CW'(W); n_st = S_DIVB;
                    end else begin
                        n_b = n_q; n_st = S_DONE;
                    end
                end
            end
            S_DONE: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_x <= n_x; r_y <= n_y; r_g <= n_g; r_k <= n_k; r_i <= n_i;
        r_a <= n_a; r_b <= n_b; r_q <= n_q; r_rem <= n_rem;
    end

    assign o_ctl.start = (r_st == S_IDLE);
    assign o_ctl.done  = (r_st == S_DONE);
    assign o_mag = r_a;
    assign o_den = r_b;
endmodule

FILE: rtl/core/rational_arithmetic_unit.sv
// Result valid follows the binary GCD loop and two 64-step
//   one-bit-per-cycle divisions in rau_gcd.
// Throughput: one item at a time; not ready until the result is taken.
// Error cases show the result the cycle after the transfer; zero results skip the GCD.
// Reset: synchronous active-low i_rst_n clears the sequencer, which drops m_axis_tvalid.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact add/sub/mul/div of two fractions, reduced to lowest terms.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // a_num, a_den, b_num, b_den (low to high), zero padded
    input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // command
    input  logic [rau_pkg::CMD_W-1:0]    s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // res_num, res_den, status (low to high), zero padded
    output logic [71:0]                  m_axis_tdata
);
    localparam int OW = OPERAND_WIDTH;
    localparam int W  = rau_pkg::ACC_W;
    localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_SUM = 3'd2,
                           S_RED = 3'd3, S_WAIT = 3'd4, S_OUT = 3'd5;

    logic [2:0] r_st, n_st;
    logic [rau_pkg::CMD_W-1:0] r_cmd;
    logic signed [OW:0] r_an, r_ad, r_bn, r_bd;
    logic [1:0] r_ph, n_ph;
    logic signed [W-1:0] r_p0, r_p1, r_p2;
    logic [W-1:0] r_num, r_den;
    logic r_neg;
    logic [rau_pkg::NUM_W-1:0] r_rnum;
    logic [rau_pkg::DEN_W-1:0] r_rden;
    logic [rau_pkg::ST_W-1:0]  r_stat;
    logic signed [OW:0] w_an, w_ad, w_bn, w_bd, w_m0, w_m1;
    logic signed [2*OW+1:0] w_prod;
    logic [W-1:0] w_num, w_mag;
    logic w_zero_den, w_div_zero;
    rau_pkg::t_ctl w_gctl_i, w_gctl_o;
    logic [W-1:0] w_gm, w_gd;

    assign w_an = (s_axis_tdata[2*OW-1]) ? -(OW+1)'($signed(s_axis_tdata[OW-1:0]))
                                         : (OW+1)'($signed(s_axis_tdata[OW-1:0]));
    assign w_ad = (s_axis_tdata[2*OW-1]) ? -(OW+1)'($signed(s_axis_tdata[2*OW-1:OW]))
                                         : (OW+1)'($signed(s_axis_tdata[2*OW-1:OW]));
    assign w_bn = (s_axis_tdata[4*OW-1]) ? -(OW+1)'($signed(s_axis_tdata[3*OW-1:2*OW]))
                                         : (OW+1)'($signed(s_axis_tdata[3*OW-1:2*OW]));
    assign w_bd = (s_axis_tdata[4*OW-1]) ? -(OW+1)'($signed(s_axis_tdata[4*OW-1:3*OW]))
                                         : (OW+1)'($signed(s_axis_tdata[4*OW-1:3*OW]));

    assign w_zero_den = (s_axis_tdata[2*OW-1:OW] == '0) ||
                        (s_axis_tdata[4*OW-1:3*OW] == '0);
    assign w_div_zero = (s_axis_tuser == rau_pkg::CMD_DIV) &&
                        (s_axis_tdata[3*OW-1:2*OW] == '0);

    // one shared multiplier, operands picked by phase
    always_comb begin
        w_m0 = r_an; w_m1 = r_bd;
        case (r_ph)
            2'd0: begin w_m0 = r_an; w_m1 = (r_cmd == rau_pkg::CMD_MUL) ? r_bn : r_bd; end
            2'd1: begin w_m0 = r_bn; w_m1 = r_ad; end
            2'd2: begin w_m0 = r_ad; w_m1 = (r_cmd == rau_pkg::CMD_DIV) ? r_bn : r_bd; end
            default: begin w_m0 = r_an; w_m1 = r_bd; end
        endcase
    end
    assign w_prod = w_m0 * w_m1;

    always_comb begin
        case (r_cmd)
            rau_pkg::CMD_ADD: w_num = r_p0 + r_p1;
            rau_pkg::CMD_SUB: w_num = r_p0 - r_p1;
            rau_pkg::CMD_DIV: w_num = r_p2[W-1] ? -r_p0 : r_p0;
            default:          w_num = r_p0;
        endcase
    end
    assign w_mag = w_num[W-1] ? -w_num : w_num;

    assign w_gctl_i.start = (r_st == S_RED);
    assign w_gctl_i.done  = 1'b0;

    rau_gcd u_gcd (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_gctl_i),
        .i_mag(r_num), .i_den(r_den),
        .o_ctl(w_gctl_o), .o_mag(w_gm), .o_den(w_gd)
    );

    always_comb begin
        n_st = r_st; n_ph = r_ph;
        case (r_st)
            S_IDLE: begin
                n_ph = 2'd0;
                if (s_axis_tvalid) begin
                    // error cases skip straight to the output
                    if (w_zero_den || w_div_zero) n_st = S_OUT;
                    else n_st = S_MUL;
                end
            end
            S_MUL: begin
                n_ph = r_ph + 1'b1;
                if (r_ph == 2'd2) n_st = S_SUM;
            end
            S_SUM: n_st = (w_num == '0) ? S_OUT : S_RED;
            S_RED: n_st = S_WAIT;
            S_WAIT: if (w_gctl_o.done) n_st = S_OUT;
            S_OUT: if (m_axis_tready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ph <= 2'd0;
        end else begin
            r_st <= n_st;
            r_ph <= n_ph;
            if (r_st == S_IDLE && s_axis_tvalid) begin
                r_cmd <= s_axis_tuser;
                r_an <= w_an; r_ad <= w_ad; r_bn <= w_bn; r_bd <= w_bd;
                r_rnum <= '0; r_rden <= rau_pkg::DEN_W'(1);
                if (w_zero_den) begin
                    r_stat <= rau_pkg::ST_ZERO_DEN;
                end else if (w_div_zero) begin
                    r_stat <= rau_pkg::ST_DIV_ZERO;
                end else begin
                    r_stat <= rau_pkg::ST_OK;
                end
            end
            if (r_st == S_MUL) begin
                case (r_ph)
                    2'd0: r_p0 <= W'(w_prod);
                    2'd1: r_p1 <= W'(w_prod);
                    default: r_p2 <= W'(w_prod);
                endcase
            end
            if (r_st == S_SUM) begin
                r_neg <= w_num[W-1];
                r_num <= w_mag;
                r_den <= r_p2[W-1] ? -r_p2 : r_p2;
            end
            if (r_st == S_WAIT && w_gctl_o.done) begin
                r_rnum <= rau_pkg::NUM_W'(r_neg ? -w_gm : w_gm);
                r_rden <= rau_pkg::DEN_W'(w_gd);
            end
        end
    end

    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tvalid = (r_st == S_OUT);
    assign m_axis_tdata  = {6'd0, r_stat, r_rden, r_rnum};
endmodule

FILE: rtl/core/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_macros.svh"
module rau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);
    `RAU_ASSERT_IMPL(a_one_item, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "busy with result")
    `RAU_ASSERT_IMPL(a_den_pos, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[63:33] != '0, "zero den")
    `RAU_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[65:64] != 2'd0,
        m_axis_tdata[32:0] == '0, "error result not 0/1")
    `RAU_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives random and directed fraction pairs through the rational arithmetic
// unit and compares every reduced result with a local predictor.
// ----------------------------------------------------------------------------
module tb_top;
    localparam int OW = rau_pkg::OPERAND_WIDTH;
    localparam int IN_W = ((4*OW+7)/8)*8;
    localparam int CW = rau_pkg::CMD_W;
    localparam logic [OW-1:0] MAX_NEG = {1'b1, {(OW-1){1'b0}}};
    localparam logic [OW-1:0] MAX_POS = {1'b0, {(OW-1){1'b1}}};

    typedef struct packed {
        logic [CW-1:0]    cmd;
        logic [OW-1:0]    an;
        logic [OW-1:0]    ad;
        logic [OW-1:0]    bn;
        logic [OW-1:0]    bd;
    } t_frac_op;

    typedef struct packed {
        logic [rau_pkg::NUM_W-1:0] num;
        logic [rau_pkg::DEN_W-1:0] den;
        logic [rau_pkg::ST_W-1:0]  st;
    } t_frac_res;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic [CW-1:0]   s_axis_tuser = '0;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [71:0]     m_axis_tdata;

    t_frac_op  pending_ops[$];
    t_frac_res expected_res[$];
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_off = 0;
    bit        in_fire = 1'b0;

    always #4 i_clk = ~i_clk;

    rational_arithmetic_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_frac_res reduce_fraction(t_frac_op op);
        t_frac_res r;
        logic signed [63:0] an, ad, bn, bd, dd;
        logic [63:0] num, den, mag, g;
        logic neg;
        an = 64'(signed'(op.an));
        ad = 64'(signed'(op.ad));
        bn = 64'(signed'(op.bn));
        bd = 64'(signed'(op.bd));
        r.num = '0;
        r.den = rau_pkg::DEN_W'(1);
        r.st = rau_pkg::ST_OK;
        if (ad == 0 || bd == 0) begin
            r.st = rau_pkg::ST_ZERO_DEN;
            return r;
        end
        if (op.cmd == rau_pkg::CMD_DIV && bn == 0) begin
            r.st = rau_pkg::ST_DIV_ZERO;
            return r;
        end
        if (ad < 0) begin
            an = -an;
            ad = -ad;
        end
        if (bd < 0) begin
            bn = -bn;
            bd = -bd;
        end
        case (op.cmd)
            rau_pkg::CMD_ADD: begin
                num = an*bd + bn*ad;
                den = ad*bd;
            end
            rau_pkg::CMD_SUB: begin
                num = an*bd - bn*ad;
                den = ad*bd;
            end
            rau_pkg::CMD_MUL: begin
                num = an*bn;
                den = ad*bd;
            end
            default: begin
                dd = ad*bn;
                num = an*bd;
                if (dd < 0) begin
                    num = -num;
                    den = -dd;
                end else begin
                    den = dd;
                end
            end
        endcase
        if (num == 0) return r;
        neg = num[63];
        mag = neg ? -num : num;
        g = gcd64(mag, den);
        if (g == 0) g = 1;
        mag = mag / g;
        den = den / g;
        num = neg ? -mag : mag;
        r.num = num[rau_pkg::NUM_W-1:0];
        r.den = den[rau_pkg::DEN_W-1:0];
        return r;
    endfunction

    // Extremes, zero and small operands (which keep the GCD loop short) mixed with full range.
    function automatic logic [OW-1:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return MAX_NEG;
            1: return MAX_POS;
            2: return '0;
            3, 4, 5: return OW'($urandom_range(0, 40)) - OW'(20);
            default: return OW'($urandom);
        endcase
    endfunction

    task automatic queue_op(logic [CW-1:0] c, logic [OW-1:0] an, logic [OW-1:0] ad,
                            logic [OW-1:0] bn, logic [OW-1:0] bd);
        t_frac_op op;
        op.cmd = c;
        op.an = an;
        op.ad = ad;
        op.bn = bn;
        op.bd = bd;
        pending_ops.push_back(op);
    endtask

    // Input transfer seen at the rising edge, used by the driver.
    always @(posedge i_clk) begin
        in_fire <= s_axis_tvalid && s_axis_tready;
    end

    // Driver: inputs change on the falling edge.
    always @(negedge i_clk) begin
        t_frac_op op;
        if (i_rst_n) begin
            if (s_axis_tvalid && !in_fire) begin
                // hold current transfer
            end else if (pending_ops.size() != 0 &&
                         $urandom_range(1, 100) > send_idle_pct) begin
                op = pending_ops.pop_front();
                s_axis_tdata <= IN_W'({op.bd, op.bn, op.ad, op.an});
                s_axis_tuser <= op.cmd;
                s_axis_tvalid <= 1'b1;
                expected_res.push_back(reduce_fraction(op));
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: ready changes on the falling edge, long hold-off counted here.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(1, 100) > recv_stall_pct);
            end
        end
    end

    // Monitor: sample on the rising edge.
    always @(posedge i_clk) begin
        t_frac_res exp_r, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.num = m_axis_tdata[rau_pkg::NUM_W-1:0];
            got.den = m_axis_tdata[rau_pkg::NUM_W +: rau_pkg::DEN_W];
            got.st  = m_axis_tdata[rau_pkg::NUM_W+rau_pkg::DEN_W +: rau_pkg::ST_W];
            if (expected_res.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
            end else begin
                exp_r = expected_res.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp num=%0d den=%0d st=%0d got num=%0d den=%0d st=%0d",
                                 $signed(exp_r.num), exp_r.den, exp_r.st,
                                 $signed(got.num), got.den, got.st);
                end
            end
        end
    end

    task automatic wait_drain();
        while (pending_ops.size() != 0 || s_axis_tvalid || expected_res.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            queue_op(CW'($urandom), rand_operand(), rand_operand(),
                     rand_operand(), rand_operand());
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every command, error cases.
        for (int c = 0; c < 4; c++) begin
            queue_op(CW'(c), MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG);
            queue_op(CW'(c), MAX_POS, OW'(1), MAX_NEG, MAX_POS);
            queue_op(CW'(c), MAX_NEG, MAX_POS, MAX_POS, 16'hffff);
            queue_op(CW'(c), OW'(0), OW'(5), OW'(3), 16'hfff9);
        end
        queue_op(rau_pkg::CMD_ADD, OW'(1), OW'(0), OW'(1), OW'(1));
        queue_op(rau_pkg::CMD_DIV, OW'(1), OW'(2), OW'(0), OW'(0));
        queue_op(rau_pkg::CMD_DIV, OW'(3), OW'(4), OW'(0), OW'(7));
        queue_op(rau_pkg::CMD_DIV, OW'(3), OW'(4), OW'(0), 16'hfffe);
        queue_op(rau_pkg::CMD_SUB, OW'(1), OW'(2), OW'(1), OW'(2));
        queue_op(rau_pkg::CMD_DIV, OW'(6), 16'hfffc, 16'hfffd, OW'(8));
        queue_op(rau_pkg::CMD_MUL, OW'(4), OW'(6), OW'(9), OW'(10));
        wait_drain();

        send_idle_pct = 0;  recv_stall_pct = 0;  run_random(500);
        wait_drain();
        send_idle_pct = 86; recv_stall_pct = 0;  run_random(350);
        wait_drain();
        send_idle_pct = 0;  recv_stall_pct = 86; run_random(350);
        wait_drain();
        // Long receiver hold-off while the sender keeps offering.
        send_idle_pct = 0;  recv_stall_pct = 0;
        @(negedge i_clk);
        hold_off <= 600;
        run_random(50);
        wait_drain();
        send_idle_pct = 25; recv_stall_pct = 25; run_random(600);
        wait_drain();
        for (int i = 0; i < 400; i++) @(posedge i_clk);
        if (mismatches == 0 && expected_res.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #40ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
